// File: sv/assert_macros.svh
// Assertion helpers used by the checker file qrc_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define QRC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define QRC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/qrc_pkg.sv
package qrc_pkg;

  localparam int VAL_W       = 32;
  localparam int TALLY_W     = 8;
  localparam int IN_TDATA_W  = 128;
  localparam int OUT_TDATA_W = 168;
  localparam int OUT_TUSER_W = 2;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_READER_ROLE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SERVER_COUNT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FAILURE_BOUND   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OPERATION_LIMIT = 2'd3;

  localparam logic ACT_INVOKE = 1'b0;
  localparam logic ACT_REPLY  = 1'b1;

  localparam logic KIND_QUERY = 1'b0;
  localparam logic KIND_WRITE = 1'b1;

  localparam logic [TALLY_W-1:0] TALLY_MAX = '1;
  localparam logic [VAL_W-1:0]   COUNT_MAX = '1;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_ONE  = 2'd1,
    PH_TWO  = 2'd2
  } phase_t;

  typedef struct packed {
    logic             is_reply;
    logic [VAL_W-1:0] write_value;
    logic [VAL_W-1:0] reply_ts;
    logic [VAL_W-1:0] reply_value;
    logic [VAL_W-1:0] reply_counter;
  } item_t;

  typedef struct packed {
    logic             send_valid;
    logic             send_kind;
    logic [VAL_W-1:0] send_ts;
    logic [VAL_W-1:0] send_value;
    logic [VAL_W-1:0] send_counter;
    logic             op_complete;
    logic [VAL_W-1:0] result_ts;
    logic [VAL_W-1:0] result_value;
    logic             refused;
  } result_t;

  typedef struct packed {
    logic                  we;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_write_t;

endpackage

// File: sv/quorum_register_client_unit.sv
// Quorum register client: client side of a quorum-replicated atomic register.
// s_axis carries invokes (tuser = 0) and server replies (tuser = 1).
// m_axis returns exactly one result word per accepted input word.
// Config port: cfg_we / cfg_index / cfg_data write reader_role (0),
// server_count (1), failure_bound (2), operation_limit (3); a write takes
// effect at the clock edge it is seen; the user must write only while the
// block is idle, and the block itself does not enforce this. A word passes
// through the 2-entry input queue and then the registered result stage.
// Throughput: one word per cycle while m_axis_tready is high; the protocol
// state update (compares, increments, phase change) is combinational in the
// back end. When m_axis_tready is low, the result holds and the input queue
// absorbs up to two more words before s_axis_tready drops.
// Synchronous reset clears phase, tally, timestamp, value, counters and the
// queues, and restores configuration defaults (writer, 1 server, 0 failures,
// limit 100).
module quorum_register_client_unit #(
  parameter int unsigned SERVER_LIMIT = 255
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // write_value, reply_ts, reply_value, reply_counter
  input  logic [qrc_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  // action
  input  logic                                s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // send_ts, send_value, send_counter, op_complete, result_ts, result_value,
  // refused, zero pad
  output logic [qrc_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  // send_valid, send_kind
  output logic [qrc_pkg::OUT_TUSER_W-1:0]     m_axis_tuser,
  input  logic                                cfg_we,
  input  logic [qrc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [qrc_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import qrc_pkg::*;

  item_t      item;
  logic       item_valid;
  logic       item_ready;
  result_t    res;
  cfg_write_t cfg;

  assign cfg.we    = cfg_we;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  qrc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_data    (s_axis_tdata),
    .in_action  (s_axis_tuser),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item)
  );

  qrc_back #(
    .SERVER_LIMIT (SERVER_LIMIT)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .res_valid  (m_axis_tvalid),
    .res_ready  (m_axis_tready),
    .res        (res)
  );

  assign m_axis_tdata = {6'b0, res.refused, res.result_value, res.result_ts,
                         res.op_complete, res.send_counter, res.send_value,
                         res.send_ts};
  assign m_axis_tuser = {res.send_kind, res.send_valid};

endmodule

// File: sv/qrc_front.sv
module qrc_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [qrc_pkg::IN_TDATA_W-1:0] in_data,
  input  logic                          in_action,
  output logic                          item_valid,
  input  logic                          item_ready,
  output qrc_pkg::item_t                item
);
  import qrc_pkg::*;

  item_t       slots [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        push;
  logic        pop;
  item_t       decoded;

  always_comb begin
    decoded.is_reply      = (in_action == ACT_REPLY);
    decoded.write_value   = in_data[VAL_W-1:0];
    decoded.reply_ts      = in_data[2*VAL_W-1:VAL_W];
    decoded.reply_value   = in_data[3*VAL_W-1:2*VAL_W];
    decoded.reply_counter = in_data[4*VAL_W-1:3*VAL_W];
  end

  assign in_ready   = (count != 2'd2);
  assign item_valid = (count != 2'd0);
  assign item       = slots[rd_ptr];
  assign push       = in_valid && in_ready;
  assign pop        = item_valid && item_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= decoded;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: sv/qrc_back.sv
module qrc_back #(
  parameter int unsigned SERVER_LIMIT = 255
) (
  input  logic                clk,
  input  logic                rst,
  input  qrc_pkg::cfg_write_t cfg,
  input  logic                item_valid,
  output logic                item_ready,
  input  qrc_pkg::item_t      item,
  output logic                res_valid,
  input  logic                res_ready,
  output qrc_pkg::result_t    res
);
  import qrc_pkg::*;

  localparam int unsigned SLIM = (SERVER_LIMIT > 255) ? 255 : SERVER_LIMIT;

  logic               reader_role;
  logic [7:0]         server_count;
  logic [7:0]         failure_bound;
  logic [VAL_W-1:0]   operation_limit;

  phase_t             phase, phase_next;
  logic [TALLY_W-1:0] reply_tally, reply_tally_next;
  logic [VAL_W-1:0]   local_ts, local_ts_next;
  logic [VAL_W-1:0]   local_value, local_value_next;
  logic [VAL_W-1:0]   sent_counter, sent_counter_next;
  logic [VAL_W-1:0]   invoked_count, invoked_count_next;

  logic [7:0]         servers;
  logic [7:0]         quorum;
  logic [TALLY_W-1:0] tally_inc;
  logic               take;
  result_t            res_next;

  assign servers   = (server_count > 8'(SLIM)) ? 8'(SLIM) : server_count;
  assign quorum    = (failure_bound >= servers) ? 8'd1 : servers - failure_bound;
  assign tally_inc = (reply_tally != TALLY_MAX) ? reply_tally + 1'b1 : reply_tally;

  assign item_ready = !res_valid || res_ready;
  assign take       = item_valid && item_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      reader_role     <= 1'b0;
      server_count    <= 8'd1;
      failure_bound   <= 8'd0;
      operation_limit <= 32'd100;
    end else if (cfg.we) begin
      case (cfg.index)
        CFG_READER_ROLE:     reader_role     <= cfg.data[0];
        CFG_SERVER_COUNT:    server_count    <= cfg.data[7:0];
        CFG_FAILURE_BOUND:   failure_bound   <= cfg.data[7:0];
        CFG_OPERATION_LIMIT: operation_limit <= cfg.data[VAL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_next         = phase;
    reply_tally_next   = reply_tally;
    local_ts_next      = local_ts;
    local_value_next   = local_value;
    sent_counter_next  = sent_counter;
    invoked_count_next = invoked_count;
    res_next           = '0;

    if (!item.is_reply) begin
      if (invoked_count != COUNT_MAX) begin
        invoked_count_next = invoked_count + 1'b1;
      end
      if (invoked_count_next > operation_limit) begin
        res_next.refused = 1'b1;
      end else begin
        phase_next        = PH_ONE;
        reply_tally_next  = '0;
        sent_counter_next = sent_counter + 1'b1;
        if (!reader_role) begin
          local_ts_next    = local_ts + 1'b1;
          local_value_next = item.write_value;
        end
        res_next.send_valid   = 1'b1;
        res_next.send_kind    = reader_role ? KIND_QUERY : KIND_WRITE;
        res_next.send_ts      = local_ts_next;
        res_next.send_value   = local_value_next;
        res_next.send_counter = sent_counter_next;
      end
    end else if (item.reply_counter != sent_counter || phase == PH_IDLE) begin
      res_next.refused = 1'b1;
    end else begin
      reply_tally_next = tally_inc;
      if (!reader_role) begin
        if (tally_inc >= quorum) begin
          phase_next           = PH_IDLE;
          res_next.op_complete = 1'b1;
        end
      end else begin
        case (phase)
          PH_ONE: begin
            if (local_ts < item.reply_ts) begin
              local_ts_next    = item.reply_ts;
              local_value_next = item.reply_value;
            end
            if (tally_inc >= quorum) begin
              phase_next            = PH_TWO;
              reply_tally_next      = '0;
              sent_counter_next     = sent_counter + 1'b1;
              res_next.send_valid   = 1'b1;
              res_next.send_kind    = KIND_WRITE;
              res_next.send_ts      = local_ts_next;
              res_next.send_value   = local_value_next;
              res_next.send_counter = sent_counter_next;
            end
          end
          PH_TWO: begin
            if (tally_inc >= quorum) begin
              phase_next           = PH_IDLE;
              res_next.op_complete = 1'b1;
            end
          end
          default: ;
        endcase
      end
    end

    res_next.result_ts    = local_ts_next;
    res_next.result_value = local_value_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      reply_tally   <= '0;
      local_ts      <= '0;
      local_value   <= '0;
      sent_counter  <= '0;
      invoked_count <= '0;
    end else if (take) begin
      phase         <= phase_next;
      reply_tally   <= reply_tally_next;
      local_ts      <= local_ts_next;
      local_value   <= local_value_next;
      sent_counter  <= sent_counter_next;
      invoked_count <= invoked_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (take) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res <= res_next;
    end
  end

endmodule

// File: sv/qrc_checker.sv
`include "assert_macros.svh"

module qrc_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [qrc_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic [qrc_pkg::OUT_TUSER_W-1:0] m_axis_tuser
);
  import qrc_pkg::*;

  `QRC_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result word changed while stalled")

  `QRC_ASSERT_IMP(a_no_send_zero, m_axis_tvalid && !m_axis_tuser[0], m_axis_tuser[1] == 1'b0 && m_axis_tdata[3*VAL_W-1:0] == '0, "send fields nonzero without a broadcast")

  `QRC_ASSERT_IMP(a_complete_alone, m_axis_tvalid && m_axis_tdata[3*VAL_W], !m_axis_tuser[0] && !m_axis_tdata[5*VAL_W+1], "completion together with a send or refusal")

  `QRC_ASSERT_IMP(a_refuse_silent, m_axis_tvalid && m_axis_tdata[5*VAL_W+1], !m_axis_tuser[0], "refused word carries a broadcast")

endmodule

bind quorum_register_client_unit qrc_checker u_qrc_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

// File: tb/tb_quorum_register_client_unit.sv
`timescale 1ns / 1ps
module tb_quorum_register_client_unit;
  import qrc_pkg::*;

  // Tracks the client state from accepted words and holds the results it predicts.
  class client_tracker;
    logic             reader;
    logic [7:0]       servers;
    logic [7:0]       failures;
    logic [VAL_W-1:0] op_limit;

    phase_t             phase;
    logic [TALLY_W-1:0] tally;
    logic [VAL_W-1:0]   lts;
    logic [VAL_W-1:0]   lval;
    logic [VAL_W-1:0]   sent_cnt;
    logic [VAL_W-1:0]   invoked;

    result_t pending_results[$];
    int errors;
    int n_items;
    int n_results;
    int n_sent;
    int n_done;
    int n_refused;

    function new();
      reader = 1'b0;
      servers = 8'd1;
      failures = 8'd0;
      op_limit = 32'd100;
      phase = PH_IDLE;
      tally = '0;
      lts = '0;
      lval = '0;
      sent_cnt = '0;
      invoked = '0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
      case (idx)
        CFG_READER_ROLE:     reader = v[0];
        CFG_SERVER_COUNT:    servers = v[7:0];
        CFG_FAILURE_BOUND:   failures = v[7:0];
        CFG_OPERATION_LIMIT: op_limit = v;
        default: ;
      endcase
    endfunction

    function int quorum();
      if (failures >= servers) return 1;
      return int'(servers) - int'(failures);
    endfunction

    function void broadcast(inout result_t r, input logic kind);
      sent_cnt = sent_cnt + 1;
      r.send_valid = 1'b1;
      r.send_kind = kind;
      r.send_ts = lts;
      r.send_value = lval;
      r.send_counter = sent_cnt;
      n_sent++;
    endfunction

    function void advance(item_t it);
      result_t r;
      int q;
      r = '0;
      n_items++;
      if (it.is_reply == ACT_INVOKE) begin
        if (invoked != COUNT_MAX) invoked = invoked + 1;
        if (invoked > op_limit) begin
          r.refused = 1'b1;
        end else begin
          phase = PH_ONE;
          tally = '0;
          if (reader) begin
            broadcast(r, KIND_QUERY);
          end else begin
            lts = lts + 1;
            lval = it.write_value;
            broadcast(r, KIND_WRITE);
          end
        end
      end else if (it.reply_counter != sent_cnt || phase == PH_IDLE) begin
        r.refused = 1'b1;
      end else begin
        q = quorum();
        if (tally != TALLY_MAX) tally = tally + 1'b1;
        if (!reader) begin
          if (int'(tally) >= q) begin
            phase = PH_IDLE;
            r.op_complete = 1'b1;
          end
        end else if (phase == PH_ONE) begin
          if (lts < it.reply_ts) begin
            lts = it.reply_ts;
            lval = it.reply_value;
          end
          if (int'(tally) >= q) begin
            phase = PH_TWO;
            tally = '0;
            broadcast(r, KIND_WRITE);
          end
        end else if (phase == PH_TWO) begin
          if (int'(tally) >= q) begin
            phase = PH_IDLE;
            r.op_complete = 1'b1;
          end
        end
      end
      r.result_ts = lts;
      r.result_value = lval;
      if (r.op_complete) n_done++;
      if (r.refused) n_refused++;
      pending_results.push_back(r);
    endfunction

    function void cmp(string name, logic [VAL_W-1:0] e, logic [VAL_W-1:0] a);
      if (e !== a) begin
        $error("%s: expected %0h, got %0h", name, e, a);
        errors++;
      end
    endfunction

    function void check_result(logic [OUT_TDATA_W-1:0] d, logic [OUT_TUSER_W-1:0] u);
      result_t want;
      if (pending_results.size() == 0) begin
        $error("result word with nothing outstanding");
        errors++;
        return;
      end
      want = pending_results.pop_front();
      n_results++;
      cmp("send_valid", 32'(want.send_valid), 32'(u[0]));
      cmp("send_kind", 32'(want.send_kind), 32'(u[1]));
      cmp("send_ts", want.send_ts, d[31:0]);
      cmp("send_value", want.send_value, d[63:32]);
      cmp("send_counter", want.send_counter, d[95:64]);
      cmp("op_complete", 32'(want.op_complete), 32'(d[96]));
      cmp("result_ts", want.result_ts, d[128:97]);
      cmp("result_value", want.result_value, d[160:129]);
      cmp("refused", 32'(want.refused), 32'(d[161]));
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  // write_value, reply_ts, reply_value, reply_counter
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  // action
  logic                   s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  // send_ts, send_value, send_counter, op_complete, result_ts, result_value, refused, pad
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  // send_valid, send_kind
  logic [OUT_TUSER_W-1:0] m_axis_tuser;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  client_tracker tracker = new();

  quorum_register_client_unit u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #6 clk = ~clk;

  initial begin
    #15_000_000;
    $display("[quorum_register_client_unit] ERROR");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) tracker.check_result(m_axis_tdata, m_axis_tuser);
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // receiver backpressure: runs of ready broken by stalls, sometimes long clean stretches
  initial begin
    int run;
    int stall;
    m_axis_tready <= 1'b0;
    repeat (8) @(posedge clk);
    forever begin
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 12);
      m_axis_tready <= 1'b1;
      repeat (run) @(posedge clk);
      stall = pick_gap();
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  function automatic item_t mk(logic act, logic [VAL_W-1:0] wv, logic [VAL_W-1:0] rts,
                               logic [VAL_W-1:0] rval, logic [VAL_W-1:0] rcnt);
    item_t it;
    it.is_reply = act;
    it.write_value = wv;
    it.reply_ts = rts;
    it.reply_value = rval;
    it.reply_counter = rcnt;
    return it;
  endfunction

  function automatic logic [VAL_W-1:0] pick_ts();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2, 3: return $urandom;
      default: return tracker.lts + $urandom_range(0, 4) - 2;
    endcase
  endfunction

  function automatic logic [VAL_W-1:0] stale_counter();
    case ($urandom_range(0, 2))
      0: return tracker.sent_cnt - 1;
      1: return tracker.sent_cnt + $urandom_range(1, 4);
      default: return $urandom;
    endcase
  endfunction

  // mostly well-formed traffic: invoke when idle, fresh replies while pending
  function automatic item_t random_item(int noise);
    item_t it;
    int r;
    r = $urandom_range(0, 99);
    it = mk(ACT_REPLY, $urandom, pick_ts(), $urandom, tracker.sent_cnt);
    if (tracker.phase == PH_IDLE) begin
      if (r < 85) begin
        it.is_reply = ACT_INVOKE;
        it.reply_counter = $urandom;
      end else if (r < 85 + noise) begin
        it.reply_counter = stale_counter();
      end
    end else begin
      if (r < noise / 2) begin
        it.is_reply = ACT_INVOKE;
        it.reply_counter = $urandom;
      end else if (r < noise) begin
        it.reply_counter = stale_counter();
      end
    end
    return it;
  endfunction

  task automatic send_item(item_t it);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {it.reply_counter, it.reply_value, it.reply_ts, it.write_value};
    s_axis_tuser <= it.is_reply;
    do @(posedge clk); while (!s_axis_tready);
    tracker.advance(it);
  endtask

  task automatic idle_sender(int n);
    if (n > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (tracker.pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    tracker.set_reg(idx, v);
  endtask

  task automatic write_settings(logic role, logic [7:0] srv, logic [7:0] fb,
                                logic [VAL_W-1:0] lim);
    put_reg(CFG_READER_ROLE, {31'd0, role});
    put_reg(CFG_SERVER_COUNT, {24'd0, srv});
    put_reg(CFG_FAILURE_BOUND, {24'd0, fb});
    put_reg(CFG_OPERATION_LIMIT, lim);
    cfg_we <= 1'b0;
  endtask

  task automatic run_segment(int n, int noise, bit quiet);
    repeat (n) begin
      send_item(random_item(noise));
      if (!quiet) idle_sender(pick_gap());
    end
  endtask

  initial begin
    logic             role;
    logic [7:0]       srv;
    logic [7:0]       fb;
    logic [VAL_W-1:0] lim;
    logic [VAL_W:0]   sum;
    int               noise;
    bit               quiet;

    rst <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    s_axis_tuser <= ACT_INVOKE;
    cfg_we <= 1'b0;
    cfg_index <= CFG_READER_ROLE;
    cfg_data <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // writer basics: idle reply, stale reply, completion, abandoned operation
    write_settings(1'b0, 8'd1, 8'd0, 32'd100);
    send_item(mk(ACT_REPLY, '0, '0, '0, tracker.sent_cnt));
    send_item(mk(ACT_INVOKE, '1, '0, '0, '0));
    send_item(mk(ACT_REPLY, '0, '1, '1, tracker.sent_cnt - 1));
    send_item(mk(ACT_REPLY, '1, '0, '0, tracker.sent_cnt));
    send_item(mk(ACT_REPLY, '0, '0, '0, tracker.sent_cnt));
    send_item(mk(ACT_INVOKE, '0, '1, '1, '1));
    send_item(mk(ACT_INVOKE, 32'hA5A5_5A5A, '0, '0, '0));
    send_item(mk(ACT_REPLY, '0, '0, '0, tracker.sent_cnt - 1));
    send_item(mk(ACT_REPLY, '0, '0, '0, tracker.sent_cnt));

    // reader, quorum of two: adopt highest pair, write back
    settle();
    write_settings(1'b1, 8'd3, 8'd1, '1);
    send_item(mk(ACT_INVOKE, $urandom, '0, '0, '0));
    send_item(mk(ACT_REPLY, '0, '1, 32'h1234_5678, tracker.sent_cnt));
    send_item(mk(ACT_REPLY, '0, 32'd5, '0, tracker.sent_cnt));
    send_item(mk(ACT_REPLY, '0, '0, '0, tracker.sent_cnt));

    // role flips to writer during the write-back; then timestamp wraps on invoke
    settle();
    write_settings(1'b0, 8'd255, 8'd254, '1);
    send_item(mk(ACT_REPLY, '0, '0, '0, tracker.sent_cnt));
    send_item(mk(ACT_INVOKE, '0, '0, '0, '0));

    // failure bound equal to servers: quorum clamps to one
    settle();
    write_settings(1'b1, 8'd2, 8'd2, '1);
    send_item(mk(ACT_INVOKE, '0, '0, '0, '0));
    send_item(mk(ACT_REPLY, '0, '0, '0, tracker.sent_cnt));
    send_item(mk(ACT_REPLY, '0, '0, '0, tracker.sent_cnt));

    // operation limit of zero refuses
    settle();
    write_settings(1'b1, 8'd2, 8'd2, '0);
    send_item(mk(ACT_INVOKE, '1, '1, '1, '1));
    send_item(mk(ACT_REPLY, '1, '1, '1, '1));

    // full quorum of 255 with clean traffic
    settle();
    write_settings(1'b0, 8'd255, 8'd0, '1);
    run_segment(270, 0, 1'b1);

    while (tracker.n_items < 1650) begin
      settle();
      role = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 9))
        0: srv = 8'd1;
        1: srv = 8'd255;
        default: srv = 8'($urandom_range(2, 7));
      endcase
      case ($urandom_range(0, 9))
        0: fb = 8'd0;
        1: fb = 8'd254;
        2: fb = (srv == 8'd255) ? 8'd254 : srv;
        default: fb = 8'($urandom_range(0, 3));
      endcase
      case ($urandom_range(0, 9))
        0: sum = '0;
        1: sum = {1'b0, tracker.invoked} + 33'($urandom_range(0, 3));
        2: sum = {1'b0, {VAL_W{1'b1}}};
        default: sum = {1'b0, tracker.invoked} + 33'($urandom_range(50, 300));
      endcase
      lim = sum[VAL_W] ? '1 : sum[VAL_W-1:0];
      write_settings(role, srv, fb, lim);
      noise = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(4, 15);
      quiet = ($urandom_range(0, 4) == 0);
      run_segment($urandom_range(40, 120), noise, quiet);
    end

    settle();
    repeat (10) @(posedge clk);
    $display("Sent %0d words (%0d broadcasts, %0d completed operations, %0d refusals).",
             tracker.n_items, tracker.n_sent, tracker.n_done, tracker.n_refused);
    $display("Checked %0d result words across writer and reader settings.", tracker.n_results);
    if (tracker.errors == 0) begin
      $display("[quorum_register_client_unit] OK");
    end else begin
      $display("[quorum_register_client_unit] ERROR");
    end
    $finish;
  end

endmodule
